/* rtl/core/cbc_pkg.sv */
`timescale 1ns / 1ps
package cbc_pkg;

  // Item codes
  typedef enum logic [1:0] {
    OP_REG_WR = 2'd0,
    OP_RAM_WR = 2'd1,
    OP_RAM_RD = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  // Cartridge kinds
  typedef enum logic [1:0] {
    KIND_ROM  = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_MBC3 = 2'd3
  } kind_e;

  // Clock latch sequencer: one arithmetic step per state
  typedef enum logic [3:0] {
    LAT_IDLE,
    LAT_DAY,
    LAT_DREM,
    LAT_HOUR,
    LAT_HREM,
    LAT_MIN,
    LAT_SSUM,
    LAT_SEC,
    LAT_MINC,
    LAT_HRC
  } lat_state_e;

  // Configuration register indexes
  localparam logic [1:0] REG_CART_KIND  = 2'd0;
  localparam logic [1:0] REG_ROM_BANKS  = 2'd1;
  localparam logic [1:0] REG_RAM_BANKS  = 2'd2;
  localparam logic [1:0] REG_CLOCK_PRES = 2'd3;

  localparam int QDEPTH = 2;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SIXTY         = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [7:0]  ENABLE_CODE   = 8'h0A;

  // Reciprocals, exact over the operand ranges used
  localparam logic [25:0] DAY_RECIP   = 26'd50903317; // (s >> 7) / 675, shift 35
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;     // (s >> 4) / 225, shift 21
  localparam logic [10:0] MIN_RECIP   = 11'd1093;     // (s >> 2) / 15, 10-bit, shift 14
  localparam logic [7:0]  SIXTY_RECIP = 8'd137;       // (n >> 2) / 15, 7-bit, shift 11
  localparam logic [6:0]  DAY24_RECIP = 7'd86;        // (n >> 3) / 3, 6-bit, shift 8

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rom_cnt;
    logic [2:0] ram_cnt;
    logic       clk_present;
  } cbc_cfg_t;

  // Request after classification
  typedef struct packed {
    op_e         opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic        win;       // inside the external RAM window
    logic [12:0] off;       // offset from window base
    logic [12:0] bank_off;  // offset within one bank
  } cbc_item_t;

endpackage

/* rtl/core/cbc_front.sv */
`timescale 1ns / 1ps
module cbc_front #(
  parameter int BANK_BYTES = 8192
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cbc_pkg::cbc_item_t q_item_o
);
  import cbc_pkg::*;

  logic [16:0] rem;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Window decode and offset reduction modulo the bank size
  always_comb begin
    rem = {4'b0, address_i[12:0]};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 17'(BANK_BYTES << k)) begin
        rem = rem - 17'(BANK_BYTES << k);
      end
    end
    q_item_o.opcode   = op_e'(opcode_i);
    q_item_o.address  = address_i;
    q_item_o.data     = data_i;
    q_item_o.win      = (address_i[15:13] == 3'b101);
    q_item_o.off      = address_i[12:0];
    q_item_o.bank_off = rem[12:0];
  end

endmodule

/* rtl/core/cbc_fifo.sv */
`timescale 1ns / 1ps
module cbc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cbc_pkg::cbc_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output cbc_pkg::cbc_item_t item_o
);
  import cbc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cbc_item_t       entries_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/cbc_back.sv */
`timescale 1ns / 1ps
module cbc_back #(
  parameter int RAM_BANKS  = 4,
  parameter int BANK_BYTES = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbc_pkg::cbc_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  cbc_pkg::cbc_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic [6:0]         rom_bank_high_o,
  output logic [6:0]         rom_bank_low_o,
  output logic [3:0]         ram_bank_select_o,
  output logic               ram_on_o,
  output logic               status_o
);
  import cbc_pkg::*;

  localparam int MEM_DEPTH = RAM_BANKS * BANK_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);

  // Bank and clock state
  logic [6:0]  rom_q, rom_n;
  logic        mode_q, mode_n;
  logic [3:0]  sel_q, sel_n;
  logic        ram_en_q, ram_en_n;
  logic        clk_en_q, clk_en_n;
  logic [1:0]  upper_q, upper_n;
  logic [7:0]  llb_q, llb_n;
  logic [31:0] secs_q, secs_n;
  logic [7:0]  live_q  [5];
  logic [7:0]  latch_q [5];

  // Result register
  logic        out_valid_q;
  logic [7:0]  rd_q, rd_n;
  logic        use_mem_q;
  logic [6:0]  rom_hi_q, rom_lo_q;
  logic [3:0]  sel_out_q;
  logic        on_q;
  logic        st_q, st_n;

  // Memory port
  logic [7:0]    ram_mem [MEM_DEPTH];
  logic [7:0]    mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;

  // Clock side effects
  logic          live_we, halt_copy, lat_go;

  // Latch sequencer
  lat_state_e    lat_state_q, lat_state_d;
  logic [31:0]   lat_secs_q, lat_secs_d;
  logic [16:0]   rem_q, rem_d;
  logic [15:0]   dd_q, dd_d;
  logic [4:0]    dh_q, dh_d;
  logic [5:0]    dm_q, dm_d;
  logic [8:0]    sum_q, sum_d;
  logic [7:0]    sec_q, sec_d;
  logic [7:0]    min_q, min_d;
  logic          lat_done;
  logic [7:0]    new_clk [5];

  logic          issue, clk_act, is_rd;

  assign clk_act = (cfg_i.kind == KIND_MBC3) && cfg_i.clk_present;
  assign issue   = item_valid_i && (!out_valid_q || out_ready_i) && (lat_state_q == LAT_IDLE);
  assign item_pop_o = issue;
  assign is_rd   = (item_i.opcode == OP_RAM_RD);

  // Execute one request against current state
  always_comb begin
    logic [4:0] b5;
    logic [6:0] b7;
    logic       on;
    b5 = item_i.data[4:0];
    b7 = item_i.data[6:0];
    on = 1'b0;
    rom_n = rom_q; mode_n = mode_q; sel_n = sel_q; ram_en_n = ram_en_q;
    clk_en_n = clk_en_q; upper_n = upper_q; llb_n = llb_q; secs_n = secs_q;
    rd_n = 8'h00; st_n = 1'b0;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wd = item_i.data;
    live_we = 1'b0; halt_copy = 1'b0; lat_go = 1'b0;
    case (item_i.opcode)
      OP_REG_WR: begin
        if (!item_i.address[15] && cfg_i.kind != KIND_ROM) begin
          case (cfg_i.kind)
            KIND_MBC1: begin
              case (item_i.address[14:13])
                2'b00: begin
                  if (item_i.data == 8'h00) begin
                    ram_en_n = 1'b0;
                  end else if (item_i.data == ENABLE_CODE && cfg_i.ram_cnt != 3'd0) begin
                    ram_en_n = 1'b1;
                  end
                end
                2'b01: begin
                  if ({3'b0, b5} >= cfg_i.rom_cnt) begin
                    st_n = 1'b1;
                  end else begin
                    if (b5 == 5'd0) b5 = 5'd1;
                    if (cfg_i.rom_cnt >= 8'd64) rom_n = {rom_q[6:5], b5};
                    else rom_n = {2'b00, b5};
                  end
                end
                default: begin
                  if (item_i.address[14:13] == 2'b10) begin
                    upper_n = item_i.data[1:0];
                    if (cfg_i.rom_cnt >= 8'd64) rom_n = {upper_n, rom_q[4:0]};
                  end else begin
                    mode_n = item_i.data[0];
                  end
                  // RAM bank follows the secondary register in mode 1
                  if (mode_n) begin
                    if ({1'b0, upper_n} < cfg_i.ram_cnt) sel_n = {2'b00, upper_n};
                  end else begin
                    sel_n = 4'd0;
                  end
                end
              endcase
            end
            KIND_MBC2: begin
              if (!item_i.address[14]) begin
                if (item_i.address[8]) begin
                  rom_n = (item_i.data[3:0] == 4'd0) ? 7'd1 : {3'b000, item_i.data[3:0]};
                end else begin
                  ram_en_n = (item_i.data == ENABLE_CODE);
                end
              end
            end
            default: begin
              case (item_i.address[14:13])
                2'b00: begin
                  if (item_i.data == 8'h00) begin
                    ram_en_n = 1'b0;
                    clk_en_n = 1'b0;
                  end else if (item_i.data == ENABLE_CODE) begin
                    if (cfg_i.ram_cnt != 3'd0) ram_en_n = 1'b1;
                    if (cfg_i.clk_present) clk_en_n = 1'b1;
                  end
                end
                2'b01: begin
                  if ({1'b0, b7} >= cfg_i.rom_cnt) st_n = 1'b1;
                  else rom_n = (b7 == 7'd0) ? 7'd1 : b7;
                end
                2'b10: begin
                  if (!cfg_i.clk_present) begin
                    if (item_i.data > 8'd3) st_n = 1'b1;
                    else sel_n = item_i.data[3:0];
                  end else if (item_i.data <= 8'd3 ||
                               (item_i.data >= 8'd8 && item_i.data <= 8'd12)) begin
                    sel_n = item_i.data[3:0];
                  end
                end
                default: begin
                  // Latch on a 00 then 01 sequence
                  llb_n = item_i.data;
                  if (llb_q == 8'h00 && item_i.data == 8'h01 && cfg_i.clk_present) begin
                    secs_n = 32'd0;
                    if (live_q[4][6]) halt_copy = 1'b1;
                    else lat_go = 1'b1;
                  end
                end
              endcase
            end
          endcase
        end
      end
      OP_RAM_WR, OP_RAM_RD: begin
        if (is_rd) rd_n = 8'hFF;
        on = ram_en_q || (clk_act && clk_en_q);
        if (!item_i.win) begin
          st_n = 1'b1;
        end else if (cfg_i.kind == KIND_ROM) begin
          st_n = 1'b0;
        end else if (cfg_i.kind == KIND_MBC2) begin
          if (ram_en_q) begin
            mem_addr = AW'(item_i.off[8:0]);
            mem_wd   = {4'h0, item_i.data[3:0]};
            mem_re   = is_rd;
            mem_we   = !is_rd;
          end
        end else if (on) begin
          if (sel_q >= 4'd8 && sel_q <= 4'd12 && clk_act) begin
            if (is_rd) rd_n = latch_q[sel_q[2:0]];
            else live_we = 1'b1;
          end else if (sel_q > 4'd3 || int'(sel_q) >= RAM_BANKS) begin
            st_n = 1'b1;
          end else begin
            mem_addr = AW'(int'(sel_q[1:0]) * BANK_BYTES + int'(item_i.bank_off));
            mem_re   = is_rd;
            mem_we   = !is_rd;
          end
        end
      end
      default: begin
        if (secs_q != 32'hFFFF_FFFF) secs_n = secs_q + 32'd1;
      end
    endcase
    if (!issue) begin
      mem_we = 1'b0; mem_re = 1'b0; live_we = 1'b0; halt_copy = 1'b0; lat_go = 1'b0;
    end
  end

  // Latch sequencer: reciprocal multiplies and small carries, one step per cycle
  always_comb begin
    logic [50:0] day_prod;
    logic [31:0] day_rem;
    logic [26:0] hour_prod;
    logic [11:0] hour_rem;
    logic [20:0] min_prod;
    logic [11:0] sec_sum;
    logic [14:0] carry_prod;
    logic [2:0]  carry;
    logic [8:0]  carry_rem;
    logic [12:0] hc_prod;
    logic [3:0]  hc;
    logic [8:0]  hr;
    logic [16:0] days;
    logic [7:0]  top;
    day_prod   = 51'(lat_secs_q[31:7]) * 51'(DAY_RECIP);
    day_rem    = lat_secs_q - 32'(dd_q) * 32'(SECS_PER_DAY);
    hour_prod  = 27'(rem_q[16:4]) * 27'(HOUR_RECIP);
    hour_rem   = rem_q[11:0] - 12'(dh_q) * SECS_PER_HOUR;
    min_prod   = 21'(rem_q[11:2]) * 21'(MIN_RECIP);
    sec_sum    = 12'(live_q[0]) + rem_q[11:0] - 12'(dm_q) * 12'(SIXTY);
    // Carry out of a seconds or minutes sum (at most 319)
    carry_prod = 15'(sum_q[8:2]) * 15'(SIXTY_RECIP);
    carry      = carry_prod[13:11];
    carry_rem  = sum_q - 9'(carry) * 9'(SIXTY);
    // Carry out of the hours sum (at most 283)
    hc_prod    = 13'(sum_q[8:3]) * 13'(DAY24_RECIP);
    hc         = hc_prod[11:8];
    hr         = sum_q - 9'(hc) * 9'(HOURS_PER_DAY);
    days       = 17'({live_q[4][0], live_q[3]}) + 17'(dd_q) + 17'(hc);
    top        = {live_q[4][7:1], days[8]};
    if (days > 17'd511) top[7] = 1'b1;
    new_clk[0] = sec_q;
    new_clk[1] = min_q;
    new_clk[2] = hr[7:0];
    new_clk[3] = days[7:0];
    new_clk[4] = top;

    lat_state_d = lat_state_q;
    lat_secs_d = lat_secs_q; rem_d = rem_q; sum_d = sum_q;
    dd_d = dd_q; dh_d = dh_q; dm_d = dm_q; sec_d = sec_q; min_d = min_q;
    lat_done = 1'b0;
    case (lat_state_q)
      LAT_IDLE: begin
        if (lat_go) begin
          lat_secs_d  = secs_q;
          lat_state_d = LAT_DAY;
        end
      end
      LAT_DAY: begin
        dd_d = day_prod[50:35];
        lat_state_d = LAT_DREM;
      end
      LAT_DREM: begin
        rem_d = day_rem[16:0];
        lat_state_d = LAT_HOUR;
      end
      LAT_HOUR: begin
        dh_d = hour_prod[25:21];
        lat_state_d = LAT_HREM;
      end
      LAT_HREM: begin
        rem_d = {5'b0, hour_rem};
        lat_state_d = LAT_MIN;
      end
      LAT_MIN: begin
        dm_d = min_prod[19:14];
        lat_state_d = LAT_SSUM;
      end
      LAT_SSUM: begin
        sum_d = sec_sum[8:0];
        lat_state_d = LAT_SEC;
      end
      LAT_SEC: begin
        sec_d = carry_rem[7:0];
        sum_d = 9'(live_q[1]) + 9'(dm_q) + 9'(carry);
        lat_state_d = LAT_MINC;
      end
      LAT_MINC: begin
        min_d = carry_rem[7:0];
        sum_d = 9'(live_q[2]) + 9'(dh_q) + 9'(carry);
        lat_state_d = LAT_HRC;
      end
      default: begin
        lat_done = 1'b1;
        lat_state_d = LAT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_state_q <= LAT_IDLE;
    end else begin
      lat_state_q <= lat_state_d;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk_i) begin
    lat_secs_q <= lat_secs_d;
    rem_q      <= rem_d;
    dd_q       <= dd_d;
    dh_q       <= dh_d;
    dm_q       <= dm_d;
    sum_q      <= sum_d;
    sec_q      <= sec_d;
    min_q      <= min_d;
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q <= 7'd1; mode_q <= 1'b0; sel_q <= 4'd0; ram_en_q <= 1'b0;
      clk_en_q <= 1'b0; upper_q <= 2'd0; llb_q <= 8'hFF; secs_q <= 32'd0;
      for (int i = 0; i < 5; i++) begin
        live_q[i]  <= 8'd0;
        latch_q[i] <= 8'd0;
      end
    end else if (issue) begin
      rom_q <= rom_n; mode_q <= mode_n; sel_q <= sel_n; ram_en_q <= ram_en_n;
      clk_en_q <= clk_en_n; upper_q <= upper_n; llb_q <= llb_n; secs_q <= secs_n;
      if (live_we) live_q[sel_q[2:0]] <= item_i.data;
      if (halt_copy) begin
        for (int i = 0; i < 5; i++) latch_q[i] <= live_q[i];
      end
    end else if (lat_done) begin
      for (int i = 0; i < 5; i++) begin
        live_q[i]  <= new_clk[i];
        latch_q[i] <= new_clk[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q      <= rd_n;
      use_mem_q <= mem_re;
      rom_hi_q  <= (cfg_i.kind == KIND_ROM) ? 7'd1 : rom_n;
      rom_lo_q  <= (cfg_i.kind == KIND_MBC1 && mode_n) ? (rom_n & 7'h60) : 7'd0;
      sel_out_q <= sel_n;
      on_q      <= ram_en_n;
      st_q      <= st_n;
    end
  end

  // External RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) ram_mem[mem_addr] <= mem_wd;
    if (mem_re) mem_rd_q <= ram_mem[mem_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = use_mem_q ? mem_rd_q : rd_q;
  assign rom_bank_high_o   = rom_hi_q;
  assign rom_bank_low_o    = rom_lo_q;
  assign ram_bank_select_o = sel_out_q;
  assign ram_on_o          = on_q;
  assign status_o          = st_q;

  // Checks
  a_no_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_state_q != LAT_IDLE |-> !issue) else $error("request issued during latch");
  a_issue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> out_valid_q) else $error("issued request lost");
  a_latch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_state_q == LAT_HRC |=> lat_state_q == LAT_IDLE) else $error("latch did not finish");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= 4'd12) else $error("ram select out of range");
  a_latch_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_go |=> lat_state_q == LAT_DAY && secs_q == 32'd0) else $error("latch did not start");

endmodule

/* rtl/core/cartridge_bank_controller_core.sv */
`timescale 1ns / 1ps
// Cartridge bank controller (MBC1 / MBC2 / MBC3 with RAM and clock).
// Input channel: in_valid_i/in_ready_o with opcode_i, address_i, data_i.
// Each request is a register write, RAM write, RAM read or one-second tick.
// Output channel: out_valid_o/out_ready_i; one result per request carrying
// read data, the mapped ROM banks, RAM select, RAM enable and a status bit.
// Requests enter a two-entry queue and are executed by the back end, one per
// cycle unless a latch runs or a result is held; each result is registered
// after the queue, and a new request can be taken every cycle while the
// queue is not full. RAM reads use a registered memory port. A clock latch
// on an MBC3 with a running clock starts a sequencer of reciprocal multiplies
// and carries; no request executes meanwhile. A halted clock is copied as is.
// When the receiver stalls, the held result keeps the back end waiting and the
// queue fills, after which in_ready_o drops.
// Reset (rst_ni low) clears bank registers, flags, clock and the queue; RAM
// contents are not cleared. Configuration is an APB port with registers
// cart_kind, rom_bank_count, ram_bank_count, clock_present at 0x0,4,8,C;
// write it only while no request is in flight.
module cartridge_bank_controller_core #(
  parameter int RAM_BANKS  = 4,
  parameter int BANK_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [6:0]  rom_bank_high_o,
  output logic [6:0]  rom_bank_low_o,
  output logic [3:0]  ram_bank_select_o,
  output logic        ram_on_o,
  output logic        status_o
);
  import cbc_pkg::*;

  cbc_cfg_t  cfg_q;
  cbc_item_t push_item, head_item;
  logic      q_full, q_push, q_valid, q_pop, cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind        <= KIND_ROM;
      cfg_q.rom_cnt     <= 8'd2;
      cfg_q.ram_cnt     <= 3'd0;
      cfg_q.clk_present <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CART_KIND:  cfg_q.kind        <= kind_e'(pwdata[1:0]);
        REG_ROM_BANKS:  cfg_q.rom_cnt     <= pwdata[7:0];
        REG_RAM_BANKS:  cfg_q.ram_cnt     <= pwdata[2:0];
        default:        cfg_q.clk_present <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CART_KIND:  prdata = {30'b0, cfg_q.kind};
      REG_ROM_BANKS:  prdata = {24'b0, cfg_q.rom_cnt};
      REG_RAM_BANKS:  prdata = {29'b0, cfg_q.ram_cnt};
      default:        prdata = {31'b0, cfg_q.clk_present};
    endcase
  end

  cbc_front #(.BANK_BYTES(BANK_BYTES)) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .address_i  (address_i),
    .data_i     (data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  cbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  cbc_back #(.RAM_BANKS(RAM_BANKS), .BANK_BYTES(BANK_BYTES)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .item_valid_i      (q_valid),
    .item_i            (head_item),
    .item_pop_o        (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .rom_bank_high_o   (rom_bank_high_o),
    .rom_bank_low_o    (rom_bank_low_o),
    .ram_bank_select_o (ram_bank_select_o),
    .ram_on_o          (ram_on_o),
    .status_o          (status_o)
  );

endmodule

/* dv/cbc_checker.sv */
`timescale 1ns / 1ps
module cbc_checker #(
  parameter int RAM_BANKS  = 4,
  parameter int BANK_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  read_data_i,
  input  logic [6:0]  rom_bank_high_i,
  input  logic [6:0]  rom_bank_low_i,
  input  logic [3:0]  ram_bank_select_i,
  input  logic        ram_on_i,
  input  logic        status_i,
  output int          pending_o,
  output int          fails_o
);
  import cbc_pkg::*;

  typedef struct packed {
    logic [7:0] rd;
    logic [6:0] high;
    logic [6:0] low;
    logic [3:0] sel;
    logic       on;
    logic       st;
  } bank_result_t;

  // Configuration copy
  kind_e       kind;
  logic [7:0]  rom_cnt;
  logic [2:0]  ram_cnt;
  logic        clk_pres;

  // Cartridge state
  logic [7:0]  ram_mem [RAM_BANKS*BANK_BYTES];
  logic [6:0]  rom_bank;
  logic        mode;
  logic [3:0]  ram_sel;
  logic        ram_en;
  logic        clk_en;
  logic [7:0]  latch_prev;
  logic [31:0] secs;
  logic [1:0]  upper;
  logic [7:0]  live [5];
  logic [7:0]  held [5];

  bank_result_t expected_q[$];

  function automatic logic rtc_on();
    return kind == KIND_MBC3 && clk_pres;
  endfunction

  // Fold the counted seconds into the live clock, then copy it out
  function automatic void latch_rtc();
    int unsigned d, dd, dh, dm, ds, s, m, h, days;
    logic [7:0] top;
    if (!live[4][6]) begin
      d = secs;
      dd = d / 86400;
      d = d % 86400;
      dh = d / 3600;
      d = d % 3600;
      dm = d / 60;
      ds = d % 60;
      s = live[0] + ds;
      m = live[1] + dm;
      h = live[2] + dh;
      days = {live[4][0], live[3]} + dd;
      m = m + s / 60;
      s = s % 60;
      h = h + m / 60;
      m = m % 60;
      days = days + h / 24;
      h = h % 24;
      top = (live[4] & 8'hFE) | 8'(days[8]);
      if (days > 511) top = top | 8'h80;
      live[0] = s[7:0];
      live[1] = m[7:0];
      live[2] = h[7:0];
      live[3] = days[7:0];
      live[4] = top;
    end
    secs = 0;
    for (int i = 0; i < 5; i++) held[i] = live[i];
  endfunction

  function automatic void mbc1_select();
    if (mode) begin
      if (upper < ram_cnt) ram_sel = {2'b00, upper};
    end else begin
      ram_sel = 4'd0;
    end
  endfunction

  // Control register write; returns the status bit
  function automatic logic write_ctrl(logic [15:0] a, logic [7:0] d);
    logic [6:0] b;
    logic go;
    if (a > 16'h7FFF || kind == KIND_ROM) return 1'b0;
    if (kind == KIND_MBC1) begin
      if (a <= 16'h1FFF) begin
        if (d == 8'h00) ram_en = 1'b0;
        else if (d == ENABLE_CODE && ram_cnt > 0) ram_en = 1'b1;
      end else if (a <= 16'h3FFF) begin
        b = {2'b00, d[4:0]};
        if (b >= rom_cnt) return 1'b1;
        if (b == 0) b = 7'd1;
        if (rom_cnt >= 64) rom_bank = (rom_bank & 7'h60) | b;
        else rom_bank = b;
      end else if (a <= 16'h5FFF) begin
        upper = d[1:0];
        if (rom_cnt >= 64) rom_bank = {upper, rom_bank[4:0]};
        mbc1_select();
      end else begin
        mode = d[0];
        mbc1_select();
      end
      return 1'b0;
    end
    if (kind == KIND_MBC2) begin
      if (a > 16'h3FFF) return 1'b0;
      if (a[8]) rom_bank = (d[3:0] == 0) ? 7'd1 : {3'b000, d[3:0]};
      else ram_en = (d == ENABLE_CODE);
      return 1'b0;
    end
    // MBC3
    if (a <= 16'h1FFF) begin
      if (d == 8'h00) begin
        ram_en = 1'b0;
        clk_en = 1'b0;
      end else if (d == ENABLE_CODE) begin
        if (ram_cnt > 0) ram_en = 1'b1;
        if (clk_pres) clk_en = 1'b1;
      end
    end else if (a <= 16'h3FFF) begin
      b = d[6:0];
      if (b >= rom_cnt) return 1'b1;
      rom_bank = (b == 0) ? 7'd1 : b;
    end else if (a <= 16'h5FFF) begin
      if (!clk_pres) begin
        if (d > 3) return 1'b1;
        ram_sel = d[3:0];
      end else if (d <= 3 || (d >= 8 && d <= 8'h0C)) begin
        ram_sel = d[3:0];
      end
    end else begin
      go = latch_prev == 8'h00 && d == 8'h01 && clk_pres;
      latch_prev = d;
      if (go) latch_rtc();
    end
    return 1'b0;
  endfunction

  // External RAM / clock register access; returns the status bit
  function automatic logic access_ram(logic is_rd, logic [15:0] a, logic [7:0] d,
                                      output logic [7:0] rd);
    logic [12:0] off;
    int slot;
    rd = 8'hFF;
    if (a < 16'hA000 || a > 16'hBFFF) return 1'b1;
    off = 13'(a - 16'hA000);
    if (kind == KIND_ROM) return 1'b0;
    if (kind == KIND_MBC2) begin
      if (!ram_en) return 1'b0;
      slot = off % 13'h200;
      if (is_rd) rd = ram_mem[slot];
      else ram_mem[slot] = {4'h0, d[3:0]};
      return 1'b0;
    end
    if (!(ram_en || (rtc_on() && clk_en))) return 1'b0;
    if (ram_sel >= 8 && ram_sel <= 4'hC && rtc_on()) begin
      if (is_rd) rd = held[ram_sel - 8];
      else live[ram_sel - 8] = d;
      return 1'b0;
    end
    if (ram_sel > 3 || ram_sel >= RAM_BANKS) return 1'b1;
    slot = ram_sel * BANK_BYTES + off % BANK_BYTES;
    if (is_rd) rd = ram_mem[slot];
    else ram_mem[slot] = d;
    return 1'b0;
  endfunction

  function automatic bank_result_t predict_bank(op_e op, logic [15:0] a, logic [7:0] d);
    bank_result_t r;
    logic [7:0] rd;
    r = '0;
    case (op)
      OP_REG_WR: r.st = write_ctrl(a, d);
      OP_RAM_WR: r.st = access_ram(1'b0, a, d, rd);
      OP_RAM_RD: begin
        r.st = access_ram(1'b1, a, d, rd);
        r.rd = rd;
      end
      default: if (secs != 32'hFFFF_FFFF) secs = secs + 1;
    endcase
    r.high = (kind == KIND_ROM) ? 7'd1 : rom_bank;
    r.low  = (kind == KIND_MBC1 && mode) ? (rom_bank & 7'h60) : 7'd0;
    r.sel  = ram_sel;
    r.on   = ram_en;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bank_result_t e;
    if (!rst_ni) begin
      kind <= KIND_ROM;
      rom_cnt <= 8'd2;
      ram_cnt <= 3'd0;
      clk_pres <= 1'b0;
      rom_bank <= 7'd1;
      mode <= 1'b0;
      ram_sel <= 4'd0;
      ram_en <= 1'b0;
      clk_en <= 1'b0;
      latch_prev <= 8'hFF;
      secs <= '0;
      upper <= 2'd0;
      for (int i = 0; i < 5; i++) begin
        live[i] <= 8'h00;
        held[i] <= 8'h00;
      end
      expected_q.delete();
      pending_o <= 0;
      fails_o <= 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CART_KIND:  kind = kind_e'(pwdata[1:0]);
          REG_ROM_BANKS:  rom_cnt = pwdata[7:0];
          REG_RAM_BANKS:  ram_cnt = pwdata[2:0];
          REG_CLOCK_PRES: clk_pres = pwdata[0];
          default: ;
        endcase
      end
      // Accepted request
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_bank(op_e'(opcode_i), address_i, data_i));
      // Accepted result
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          fails_o = fails_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (read_data_i !== e.rd) begin
            $error("read_data: expected %h, got %h", e.rd, read_data_i);
            fails_o = fails_o + 1;
          end
          if (rom_bank_high_i !== e.high) begin
            $error("rom_bank_high: expected %h, got %h", e.high, rom_bank_high_i);
            fails_o = fails_o + 1;
          end
          if (rom_bank_low_i !== e.low) begin
            $error("rom_bank_low: expected %h, got %h", e.low, rom_bank_low_i);
            fails_o = fails_o + 1;
          end
          if (ram_bank_select_i !== e.sel) begin
            $error("ram_bank_select: expected %h, got %h", e.sel, ram_bank_select_i);
            fails_o = fails_o + 1;
          end
          if (ram_on_i !== e.on) begin
            $error("ram_on: expected %b, got %b", e.on, ram_on_i);
            fails_o = fails_o + 1;
          end
          if (status_i !== e.st) begin
            $error("status: expected %b, got %b", e.st, status_i);
            fails_o = fails_o + 1;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [15:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [6:0]  rom_bank_high_o;
  logic [6:0]  rom_bank_low_o;
  logic [3:0]  ram_bank_select_o;
  logic        ram_on_o;
  logic        status_o;

  int    pending;
  int    fails;
  int    cycles = 0;
  int    stall_left = 0;
  bit    rx_steady = 1'b0;
  bit    tx_steady = 1'b0;
  kind_e cur_kind = KIND_ROM;

  always #2 clk_i = ~clk_i;

  cartridge_bank_controller_core dut (.*);

  cbc_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .address_i, .data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .read_data_i(read_data_o),
    .rom_bank_high_i(rom_bank_high_o), .rom_bank_low_i(rom_bank_low_o),
    .ram_bank_select_i(ram_bank_select_o), .ram_on_i(ram_on_o),
    .status_i(status_o), .pending_o(pending), .fails_o(fails)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cartridge_bank_controller_core regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, quiet stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) rx_steady = ~rx_steady;
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i = 1'b1;
      if (rst_ni && !rx_steady) begin
        case ($urandom_range(0, 99)) inside
          [0:19]: stall_left = $urandom_range(1, 3);
          [20:21]: stall_left = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_cart(kind_e k, int rom_cnt, int ram_cnt, bit rtc);
    drain();
    cfg_write(REG_CART_KIND, 32'(k));
    cfg_write(REG_ROM_BANKS, 32'(rom_cnt));
    cfg_write(REG_RAM_BANKS, 32'(ram_cnt));
    cfg_write(REG_CLOCK_PRES, 32'(rtc));
    cur_kind = k;
    tx_steady = $urandom_range(0, 3) == 0;
  endtask

  // One request; called and returns at a falling edge
  task automatic send(op_e op, logic [15:0] a, logic [7:0] d);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      case ($urandom_range(0, 99)) inside
        [0:69]: gap = 0;
        [70:95]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    address_i = a;
    data_i = d;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Read address that only touches bytes written during setup
  function automatic logic [15:0] safe_rd_addr();
    logic [12:0] off;
    off = $urandom_range(0, 7);
    if (cur_kind == KIND_MBC2) begin
      if ($urandom_range(0, 1)) off = off + 13'h1F8;
      off = off + 13'($urandom_range(0, 15) * 16'h200);
    end else if ($urandom_range(0, 1)) begin
      off = off + 13'h1FF8;
    end
    return 16'hA000 + 16'(off);
  endfunction

  function automatic logic [15:0] outside_addr();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 16'h9FFF));
    return 16'($urandom_range(16'hC000, 16'hFFFF));
  endfunction

  // Mostly well-formed cartridge traffic, some noise
  task automatic random_traffic(int n);
    logic [7:0] d;
    op_e op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:9]: begin
          d = ($urandom_range(0, 2) == 0) ? 8'h00 :
              ($urandom_range(0, 3) != 0) ? ENABLE_CODE : 8'($urandom);
          send(OP_REG_WR, 16'($urandom_range(0, 16'h1FFF)), d);
        end
        [10:21]: send(OP_REG_WR, 16'($urandom_range(16'h2000, 16'h3FFF)), 8'($urandom));
        [22:29]: begin
          d = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15));
          send(OP_REG_WR, 16'($urandom_range(16'h4000, 16'h5FFF)), d);
        end
        [30:37]: begin
          if ($urandom_range(0, 2) != 0) begin
            send(OP_REG_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'h00);
            send(OP_REG_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'h01);
          end else begin
            send(OP_REG_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
          end
        end
        [38:54]: send(OP_RAM_WR, 16'($urandom_range(16'hA000, 16'hBFFF)), 8'($urandom));
        [55:74]: send(OP_RAM_RD, safe_rd_addr(), 8'($urandom));
        [75:87]: send(OP_TICK, 16'($urandom), 8'($urandom));
        default: begin
          op = op_e'($urandom_range(0, 3));
          send(op, op == OP_RAM_RD ? outside_addr() : 16'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ROM-only cart after reset
    send(OP_REG_WR, 16'h2000, 8'h05);
    send(OP_RAM_WR, 16'hA000, 8'h12);
    send(OP_RAM_RD, 16'hA000, 8'h00);
    send(OP_RAM_RD, 16'hFFFF, 8'hFF);

    // Fill the bytes that reads may later touch
    set_cart(KIND_MBC3, 128, 4, 1'b0);
    send(OP_REG_WR, 16'h0000, ENABLE_CODE);
    for (int b = 0; b < 4; b++) begin
      send(OP_REG_WR, 16'h4000, 8'(b));
      for (int k = 0; k < 8; k++) begin
        send(OP_RAM_WR, 16'hA000 + 16'(k), 8'($urandom));
        send(OP_RAM_WR, 16'hBFF8 + 16'(k), 8'($urandom));
        if (b == 0) send(OP_RAM_WR, 16'hA1F8 + 16'(k), 8'($urandom));
      end
    end
    random_traffic(150);

    // Clock: day overflow, halt, selects, window edges
    set_cart(KIND_MBC3, 128, 4, 1'b1);
    send(OP_REG_WR, 16'h0000, ENABLE_CODE);
    send(OP_REG_WR, 16'h4000, 8'h08);
    send(OP_RAM_WR, 16'hA000, 8'd59);
    send(OP_REG_WR, 16'h4000, 8'h09);
    send(OP_RAM_WR, 16'hA000, 8'd59);
    send(OP_REG_WR, 16'h4000, 8'h0A);
    send(OP_RAM_WR, 16'hA000, 8'd23);
    send(OP_REG_WR, 16'h4000, 8'h0B);
    send(OP_RAM_WR, 16'hA000, 8'hFF);
    send(OP_REG_WR, 16'h4000, 8'h0C);
    send(OP_RAM_WR, 16'hBFFF, 8'h01);
    send(OP_TICK, 16'h0000, 8'h00);
    send(OP_REG_WR, 16'h6000, 8'h00);
    send(OP_REG_WR, 16'h7FFF, 8'h01);
    send(OP_RAM_RD, 16'hA000, 8'h00);
    send(OP_RAM_WR, 16'hA000, 8'h40);
    send(OP_TICK, 16'hFFFF, 8'hFF);
    send(OP_REG_WR, 16'h6000, 8'h00);
    send(OP_REG_WR, 16'h6000, 8'h01);
    send(OP_RAM_RD, 16'hA000, 8'h00);
    send(OP_REG_WR, 16'h4000, 8'h05);
    send(OP_REG_WR, 16'h5FFF, 8'hFF);
    send(OP_REG_WR, 16'h8000, 8'h0A);
    send(OP_REG_WR, 16'h3FFF, 8'hFF);
    send(OP_REG_WR, 16'h2000, 8'h00);
    send(OP_RAM_RD, 16'h9FFF, 8'h00);
    send(OP_RAM_WR, 16'hC000, 8'hAA);
    send(OP_REG_WR, 16'h1FFF, 8'h00);
    send(OP_RAM_RD, 16'hA000, 8'h00);
    random_traffic(170);

    set_cart(KIND_MBC1, 128, 4, 1'b0);
    random_traffic(170);
    set_cart(KIND_MBC1, 2, 0, 1'b0);
    random_traffic(120);
    set_cart(KIND_MBC1, 32, 2, 1'b0);
    random_traffic(90);

    // Sender holds off until everything is back
    drain();
    random_traffic(80);

    set_cart(KIND_MBC2, 16, 1, 1'b0);
    random_traffic(170);
    set_cart(KIND_MBC3, 2, 0, 1'b1);
    random_traffic(150);
    set_cart(KIND_ROM, 2, 0, 1'b0);
    random_traffic(60);
    set_cart(KIND_MBC1, 64, 3, 1'b1);
    random_traffic(170);
    set_cart(KIND_MBC3, 100, 2, 1'b1);
    random_traffic(170);

    drain();
    repeat (20) @(negedge clk_i);
    if (fails == 0) begin
      $display("cartridge_bank_controller_core regression: pass");
    end else begin
      $display("cartridge_bank_controller_core regression: fail");
    end
    $finish;
  end

endmodule
